// ===== src/fbne_pkg.sv =====
// Shared constants, register indexes and controller types of the frame background noise estimator.
`default_nettype none

package fbne_pkg;

  localparam int DEF_MAX_DIM    = 4096;
  localparam int DEF_PIXEL_BITS = 16;

  // Fraction bits of the noise figure.
  localparam int FRAC_BITS = 8;

  localparam int CFG_DIM_W  = 13;
  localparam int CFG_STEP_W = 8;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_ADDR_W = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_STEP  = 2'd2;

  localparam logic [CFG_DIM_W-1:0]  RST_FRAME_WIDTH  = 13'd1232;
  localparam logic [CFG_DIM_W-1:0]  RST_FRAME_HEIGHT = 13'd816;
  localparam logic [CFG_STEP_W-1:0] RST_SAMPLE_STEP  = 8'd20;

  localparam int LEVEL_W     = 16;
  localparam int NOISE_W     = 24;
  localparam int COUNT_W     = 25;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 72;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_ROOT,
    ST_OUTPUT
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic root_init;
    logic root_step;
    logic out_load;
  } unit_cmd_t;

  typedef struct packed {
    logic frame_done;
    logic grid_empty;
    logic out_busy;
  } unit_status_t;

endpackage

`default_nettype wire

// ===== src/frame_background_noise_estimate_unit.sv =====
// Top level of the frame background and noise estimator.
//
// Takes one pixel per clock in raster order and samples the interior grid of
// rows and columns 1, 1+step, 1+2*step and so on. For each frame it reports
// one item: the minimum sample as background, the sample count and the noise
// sqrt(sum / (2 * count)) with 8 fraction bits, where sum adds the squared
// difference of each sample to its right-hand neighbour. The pixel stream
// runs at one item per cycle. The frame-end arithmetic runs in the background
// on one bit-serial divider followed by a two-bits-a-cycle square root. Only
// the last pixel of the next frame waits, and only if that computation or an
// untaken result is still outstanding. A write to the sample step holds the
// input off while the grid phases of the current position are recomputed.
`default_nettype none

module frame_background_noise_estimate_unit
  import fbne_pkg::*;
#(
  parameter int MAX_DIM    = DEF_MAX_DIM,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [15:0] pixel_value
  input  wire logic                   in_tuser,   // [0] frame_start
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // [15:0] background_level,
                                                  // [39:16] noise_level,
                                                  // [64:40] sample_count, rest zero
  output logic                        out_tuser   // [0] no_samples
);

  localparam int DIM_W = $clog2(MAX_DIM);
  localparam int CNT_W = 2 * DIM_W + 1;
  localparam int SUM_W = 2 * PIXEL_BITS + 2 * DIM_W;

  unit_cmd_t             cmd;
  unit_status_t          status;
  logic                  unit_idle;
  logic                  frame_done, grid_empty, out_busy;
  logic [SUM_W-1:0]      frame_sum;
  logic [CNT_W-1:0]      frame_count;
  logic [PIXEL_BITS-1:0] frame_min;

  fbne_grid #(
    .MAX_DIM    (MAX_DIM),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_grid (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_data       (cfg_data),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_frame_start (in_tuser),
    .unit_idle      (unit_idle),
    .frame_done     (frame_done),
    .frame_sum      (frame_sum),
    .frame_count    (frame_count),
    .frame_min      (frame_min)
  );

  assign status.frame_done = frame_done;
  assign status.grid_empty = grid_empty;
  assign status.out_busy   = out_busy;

  fbne_ctrl #(
    .MAX_DIM    (MAX_DIM),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .status    (status),
    .cmd       (cmd),
    .unit_idle (unit_idle)
  );

  fbne_dp #(
    .MAX_DIM    (MAX_DIM),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .frame_sum   (frame_sum),
    .frame_count (frame_count),
    .frame_min   (frame_min),
    .grid_empty  (grid_empty),
    .out_busy    (out_busy),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule

`default_nettype wire

// ===== src/fbne_grid.sv =====
// Pixel side: configuration registers, raster position, grid sampling and frame accumulators.
`default_nettype none

module fbne_grid
  import fbne_pkg::*;
#(
  parameter int MAX_DIM    = DEF_MAX_DIM,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_TDATA_W-1:0] in_tdata,
  input  wire logic                  in_frame_start,
  input  wire logic                  unit_idle,
  output logic                       frame_done,
  output logic [2*PIXEL_BITS+2*$clog2(MAX_DIM)-1:0] frame_sum,
  output logic [2*$clog2(MAX_DIM):0]                frame_count,
  output logic [PIXEL_BITS-1:0]                     frame_min
);

  localparam int DIM_W = $clog2(MAX_DIM);
  localparam int CNT_W = 2 * DIM_W + 1;
  localparam int SUM_W = 2 * PIXEL_BITS + 2 * DIM_W;
  localparam int SQ_W  = 2 * PIXEL_BITS;
  localparam int CW    = (DIM_W + 1 > CFG_DIM_W) ? DIM_W + 1 : CFG_DIM_W;
  localparam int PH_W  = CFG_STEP_W;
  localparam int REM_W = CFG_STEP_W + 1;
  localparam int RC_W  = $clog2(DIM_W + 1);

  logic [CFG_DIM_W-1:0]  fw_r, fw_nxt, fh_r, fh_nxt;
  logic [CFG_STEP_W-1:0] step_r, step_nxt;

  logic [DIM_W-1:0]      col_r, col_nxt, row_r, row_nxt;
  logic [PH_W-1:0]       col_ph_r, col_ph_nxt, row_ph_r, row_ph_nxt;
  logic [PIXEL_BITS-1:0] min_r, min_nxt, held_r, held_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  pend_r, pend_nxt;
  logic [CNT_W-1:0]      snap_cnt_r, snap_cnt_nxt;
  logic [PIXEL_BITS-1:0] snap_min_r, snap_min_nxt;

  logic [PIXEL_BITS-1:0] d_r, d_nxt;
  logic                  d_vld_r, d_vld_nxt, clr1_r, clr1_nxt, end1_r, end1_nxt;
  logic [SQ_W-1:0]       sq_r, sq_nxt;
  logic                  sq_vld_r, sq_vld_nxt, clr2_r, clr2_nxt, end2_r, end2_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt;

  logic                  rc_busy_r, rc_busy_nxt;
  logic [RC_W-1:0]       rc_cnt_r, rc_cnt_nxt;
  logic [DIM_W-1:0]      rc_col_num_r, rc_col_num_nxt, rc_row_num_r, rc_row_num_nxt;
  logic [PH_W-1:0]       rc_col_rem_r, rc_col_rem_nxt, rc_row_rem_r, rc_row_rem_nxt;

  logic [CW-1:0]         width_eff, height_eff, fw_ext, fh_ext;
  logic [PH_W-1:0]       step_eff;
  logic                  accept, fs, last_pos;
  logic [DIM_W-1:0]      col_e, row_e;
  logic                  pend_e;
  logic [PIXEL_BITS-1:0] min_e, pix, diff;
  logic [CNT_W-1:0]      cnt_e;
  logic                  on_col, on_row, row_end, frame_end;
  logic [PH_W-1:0]       col_ph_inc, row_ph_inc;
  logic [SUM_W-1:0]      sum_total;
  logic [REM_W-1:0]      rc_col_sh, rc_row_sh, rc_col_new, rc_row_new;

  // Dimensions are saturated to the supported range, a step of zero acts as one.
  always_comb begin
    fw_ext     = CW'(fw_r);
    fh_ext     = CW'(fh_r);
    width_eff  = (fw_ext < CW'(3)) ? CW'(3) : ((fw_ext > CW'(MAX_DIM)) ? CW'(MAX_DIM) : fw_ext);
    height_eff = (fh_ext < CW'(3)) ? CW'(3) : ((fh_ext > CW'(MAX_DIM)) ? CW'(MAX_DIM) : fh_ext);
    step_eff   = (step_r == '0) ? PH_W'(1) : step_r;
  end

  // The last pixel of a frame waits until the divide and root unit is free.
  assign last_pos  = (CW'(col_r) + CW'(1) >= width_eff) && (CW'(row_r) + CW'(1) >= height_eff);
  assign in_tready = !rc_busy_r && (unit_idle || !last_pos);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    fs     = in_frame_start;
    pix    = in_tdata[PIXEL_BITS-1:0];
    col_e  = fs ? '0 : col_r;
    row_e  = fs ? '0 : row_r;
    pend_e = pend_r && !fs;
    min_e  = fs ? '1 : min_r;
    cnt_e  = fs ? '0 : cnt_r;
    diff   = (pix >= held_r) ? pix - held_r : held_r - pix;

    on_col    = (col_e != '0) && (CW'(col_e) + CW'(1) < width_eff) && (col_ph_r == '0);
    on_row    = (row_e != '0) && (CW'(row_e) + CW'(1) < height_eff) && (row_ph_r == '0);
    row_end   = CW'(col_e) + CW'(1) >= width_eff;
    frame_end = row_end && (CW'(row_e) + CW'(1) >= height_eff);

    if (col_e == '0) begin
      col_ph_inc = '0;
    end else if (REM_W'(col_ph_r) + REM_W'(1) == REM_W'(step_eff)) begin
      col_ph_inc = '0;
    end else begin
      col_ph_inc = col_ph_r + PH_W'(1);
    end
    if (row_e == '0) begin
      row_ph_inc = '0;
    end else if (REM_W'(row_ph_r) + REM_W'(1) == REM_W'(step_eff)) begin
      row_ph_inc = '0;
    end else begin
      row_ph_inc = row_ph_r + PH_W'(1);
    end

    rc_col_sh  = {rc_col_rem_r, rc_col_num_r[DIM_W-1]};
    rc_row_sh  = {rc_row_rem_r, rc_row_num_r[DIM_W-1]};
    rc_col_new = (rc_col_sh >= REM_W'(step_eff)) ? rc_col_sh - REM_W'(step_eff) : rc_col_sh;
    rc_row_new = (rc_row_sh >= REM_W'(step_eff)) ? rc_row_sh - REM_W'(step_eff) : rc_row_sh;
  end

  always_comb begin
    fw_nxt       = fw_r;
    fh_nxt       = fh_r;
    step_nxt     = step_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    col_ph_nxt   = col_ph_r;
    row_ph_nxt   = row_ph_r;
    min_nxt      = min_r;
    held_nxt     = held_r;
    cnt_nxt      = cnt_r;
    pend_nxt     = pend_r;
    snap_cnt_nxt = snap_cnt_r;
    snap_min_nxt = snap_min_r;

    if (cfg_we) begin
      unique case (cfg_addr)
        REG_FRAME_WIDTH:  fw_nxt = cfg_data;
        REG_FRAME_HEIGHT: fh_nxt = cfg_data;
        REG_SAMPLE_STEP:  step_nxt = cfg_data[CFG_STEP_W-1:0];
        default: ;
      endcase
    end

    if (accept) begin
      min_nxt  = min_e;
      cnt_nxt  = cnt_e;
      pend_nxt = 1'b0;
      if (on_col && on_row) begin
        if (pix < min_e) begin
          min_nxt = pix;
        end
        cnt_nxt  = cnt_e + CNT_W'(1);
        held_nxt = pix;
        pend_nxt = 1'b1;
      end
      if (row_end) begin
        pend_nxt = 1'b0;
        col_nxt  = '0;
        if (frame_end) begin
          snap_cnt_nxt = cnt_nxt;
          snap_min_nxt = min_nxt;
          min_nxt      = '1;
          cnt_nxt      = '0;
          held_nxt     = '0;
          row_nxt      = '0;
        end else begin
          row_nxt    = row_e + DIM_W'(1);
          row_ph_nxt = row_ph_inc;
        end
      end else begin
        col_nxt    = col_e + DIM_W'(1);
        row_nxt    = row_e;
        col_ph_nxt = col_ph_inc;
      end
    end

    // A new step invalidates the grid phases: they are rebuilt by a bit-serial
    // remainder of the current positions while the input is held off.
    rc_busy_nxt    = rc_busy_r;
    rc_cnt_nxt     = rc_cnt_r;
    rc_col_num_nxt = rc_col_num_r;
    rc_row_num_nxt = rc_row_num_r;
    rc_col_rem_nxt = rc_col_rem_r;
    rc_row_rem_nxt = rc_row_rem_r;
    if (cfg_we && cfg_addr == REG_SAMPLE_STEP) begin
      rc_busy_nxt    = 1'b1;
      rc_cnt_nxt     = '0;
      rc_col_num_nxt = (col_nxt == '0) ? '0 : col_nxt - DIM_W'(1);
      rc_row_num_nxt = (row_nxt == '0) ? '0 : row_nxt - DIM_W'(1);
      rc_col_rem_nxt = '0;
      rc_row_rem_nxt = '0;
    end else if (rc_busy_r) begin
      rc_col_num_nxt = rc_col_num_r << 1;
      rc_row_num_nxt = rc_row_num_r << 1;
      rc_col_rem_nxt = PH_W'(rc_col_new);
      rc_row_rem_nxt = PH_W'(rc_row_new);
      rc_cnt_nxt     = rc_cnt_r + RC_W'(1);
      if (rc_cnt_r == RC_W'(DIM_W - 1)) begin
        rc_busy_nxt = 1'b0;
        col_ph_nxt  = PH_W'(rc_col_new);
        row_ph_nxt  = PH_W'(rc_row_new);
      end
    end
  end

  // Square-and-sum pipeline: difference, square, then accumulate.
  always_comb begin
    d_nxt      = diff;
    d_vld_nxt  = accept && pend_e;
    clr1_nxt   = accept && fs;
    end1_nxt   = accept && frame_end;
    sq_nxt     = SQ_W'(d_r) * SQ_W'(d_r);
    sq_vld_nxt = d_vld_r;
    clr2_nxt   = clr1_r;
    end2_nxt   = end1_r;
    sum_total  = (clr2_r ? '0 : sum_r) + (sq_vld_r ? SUM_W'(sq_r) : '0);
    sum_nxt    = end2_r ? '0 : sum_total;
  end

  assign frame_done  = end2_r;
  assign frame_sum   = sum_total;
  assign frame_count = snap_cnt_r;
  assign frame_min   = snap_min_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r         <= RST_FRAME_WIDTH;
      fh_r         <= RST_FRAME_HEIGHT;
      step_r       <= RST_SAMPLE_STEP;
      col_r        <= '0;
      row_r        <= '0;
      col_ph_r     <= '0;
      row_ph_r     <= '0;
      min_r        <= '1;
      held_r       <= '0;
      cnt_r        <= '0;
      pend_r       <= 1'b0;
      d_vld_r      <= 1'b0;
      clr1_r       <= 1'b0;
      end1_r       <= 1'b0;
      sq_vld_r     <= 1'b0;
      clr2_r       <= 1'b0;
      end2_r       <= 1'b0;
      sum_r        <= '0;
      rc_busy_r    <= 1'b0;
      rc_cnt_r     <= '0;
    end else begin
      fw_r         <= fw_nxt;
      fh_r         <= fh_nxt;
      step_r       <= step_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      col_ph_r     <= col_ph_nxt;
      row_ph_r     <= row_ph_nxt;
      min_r        <= min_nxt;
      held_r       <= held_nxt;
      cnt_r        <= cnt_nxt;
      pend_r       <= pend_nxt;
      d_vld_r      <= d_vld_nxt;
      clr1_r       <= clr1_nxt;
      end1_r       <= end1_nxt;
      sq_vld_r     <= sq_vld_nxt;
      clr2_r       <= clr2_nxt;
      end2_r       <= end2_nxt;
      sum_r        <= sum_nxt;
      rc_busy_r    <= rc_busy_nxt;
      rc_cnt_r     <= rc_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    snap_cnt_r   <= snap_cnt_nxt;
    snap_min_r   <= snap_min_nxt;
    d_r          <= d_nxt;
    sq_r         <= sq_nxt;
    rc_col_num_r <= rc_col_num_nxt;
    rc_row_num_r <= rc_row_num_nxt;
    rc_col_rem_r <= rc_col_rem_nxt;
    rc_row_rem_r <= rc_row_rem_nxt;
  end

endmodule

`default_nettype wire

// ===== src/fbne_dp.sv =====
// Frame-end datapath: shared divide and square-root unit and the result register.
`default_nettype none

module fbne_dp
  import fbne_pkg::*;
#(
  parameter int MAX_DIM    = DEF_MAX_DIM,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire unit_cmd_t              cmd,
  input  wire logic [2*PIXEL_BITS+2*$clog2(MAX_DIM)-1:0] frame_sum,
  input  wire logic [2*$clog2(MAX_DIM):0]                frame_count,
  input  wire logic [PIXEL_BITS-1:0]                     frame_min,
  output logic                        grid_empty,
  output logic                        out_busy,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic                        out_tuser
);

  localparam int DIM_W    = $clog2(MAX_DIM);
  localparam int CNT_W    = 2 * DIM_W + 1;
  localparam int SUM_W    = 2 * PIXEL_BITS + 2 * DIM_W;
  localparam int DEN_W    = CNT_W + 1;
  localparam int NUM_W    = SUM_W + 2 * FRAC_BITS;
  localparam int SCALED_W = 2 * PIXEL_BITS + 2 * FRAC_BITS;
  localparam int ROOT_W   = SCALED_W / 2;

  logic [DEN_W-1:0]      den_r, drem_r;
  logic [NUM_W-1:0]      num_r;
  logic [SCALED_W-1:0]   quo_r;
  logic [ROOT_W:0]       srem_r;
  logic [ROOT_W-1:0]     root_r;
  logic [PIXEL_BITS-1:0] min_hold_r;
  logic [CNT_W-1:0]      cnt_hold_r;
  logic                  empty_r;

  logic [LEVEL_W-1:0]    out_bg_r;
  logic [NOISE_W-1:0]    out_noise_r;
  logic [COUNT_W-1:0]    out_cnt_r;
  logic                  out_empty_r, out_valid_r;

  logic [DEN_W:0]        div_sh;
  logic                  div_ge;
  logic [ROOT_W+2:0]     root_sh, root_trial;
  logic                  root_ge;

  assign grid_empty = (frame_count == '0);
  assign out_busy   = out_valid_r && !out_tready;

  // One quotient bit per divide step, one root bit per root step.
  always_comb begin
    div_sh     = {drem_r, num_r[NUM_W-1]};
    div_ge     = div_sh >= {1'b0, den_r};
    root_sh    = {srem_r, quo_r[SCALED_W-1 -: 2]};
    root_trial = (ROOT_W + 3)'({root_r, 2'b01});
    root_ge    = root_sh >= root_trial;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      den_r      <= {frame_count, 1'b0};
      num_r      <= {frame_sum, (2 * FRAC_BITS)'(0)};
      drem_r     <= '0;
      quo_r      <= '0;
      min_hold_r <= frame_min;
      cnt_hold_r <= frame_count;
      empty_r    <= grid_empty;
    end
    if (cmd.div_step) begin
      drem_r <= div_ge ? DEN_W'(div_sh - {1'b0, den_r}) : DEN_W'(div_sh);
      quo_r  <= {quo_r[SCALED_W-2:0], div_ge};
      num_r  <= num_r << 1;
    end
    if (cmd.root_init) begin
      srem_r <= '0;
      root_r <= '0;
    end
    if (cmd.root_step) begin
      srem_r <= root_ge ? (ROOT_W + 1)'(root_sh - root_trial) : (ROOT_W + 1)'(root_sh);
      root_r <= {root_r[ROOT_W-2:0], root_ge};
      quo_r  <= quo_r << 2;
    end
    if (cmd.out_load) begin
      out_bg_r    <= empty_r ? '0 : LEVEL_W'(min_hold_r);
      out_noise_r <= empty_r ? '0 : NOISE_W'(root_r);
      out_cnt_r   <= COUNT_W'(cnt_hold_r);
      out_empty_r <= empty_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_cnt_r, out_noise_r, out_bg_r});
  assign out_tuser  = out_empty_r;

endmodule

`default_nettype wire

// ===== src/fbne_ctrl.sv =====
// Controller that sequences the frame-end divide, square root and result hand-over.
`default_nettype none

module fbne_ctrl
  import fbne_pkg::*;
#(
  parameter int MAX_DIM    = DEF_MAX_DIM,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire unit_status_t status,
  output unit_cmd_t         cmd,
  output logic              unit_idle
);

  localparam int DIM_W    = $clog2(MAX_DIM);
  localparam int SUM_W    = 2 * PIXEL_BITS + 2 * DIM_W;
  localparam int NUM_W    = SUM_W + 2 * FRAC_BITS;
  localparam int SCALED_W = 2 * PIXEL_BITS + 2 * FRAC_BITS;
  localparam int ROOT_W   = SCALED_W / 2;
  localparam int ITER_W   = $clog2(NUM_W);

  ctrl_state_t       state_r, state_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      iter_r  <= iter_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    iter_nxt  = iter_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (status.frame_done) begin
          cmd.load  = 1'b1;
          iter_nxt  = '0;
          // An empty grid has nothing to divide by.
          state_nxt = status.grid_empty ? ST_OUTPUT : ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (iter_r == ITER_W'(NUM_W - 1)) begin
          cmd.root_init = 1'b1;
          iter_nxt      = '0;
          state_nxt     = ST_ROOT;
        end else begin
          iter_nxt = iter_r + ITER_W'(1);
        end
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (iter_r == ITER_W'(ROOT_W - 1)) begin
          iter_nxt  = '0;
          state_nxt = ST_OUTPUT;
        end else begin
          iter_nxt = iter_r + ITER_W'(1);
        end
      end
      ST_OUTPUT: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
    endcase
  end

  assign unit_idle = (state_r == ST_IDLE);

endmodule

`default_nettype wire

// ===== tb/frame_background_noise_estimate_unit_test.sv =====
// Self-checking testbench for the frame background and noise estimator.
`timescale 1ns / 100ps

module frame_background_noise_estimate_unit_test
  import fbne_pkg::*;
();

  localparam int SETTLE_CYCLES  = 200;
  localparam int HOLD_CYCLES    = 600;
  localparam int RANDOM_PIXELS  = 850;
  localparam int RANDOM_RESULTS = 12;

  typedef struct packed {
    logic [LEVEL_W-1:0] background;
    logic [NOISE_W-1:0] noise;
    logic [COUNT_W-1:0] count;
    logic               empty;
  } frame_stats_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [15:0] pixel_value
  logic                   in_tuser;   // [0] frame_start
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [15:0] background_level, [39:16] noise_level,
                                      // [64:40] sample_count, rest zero
  logic                   out_tuser;  // [0] no_samples

  frame_background_noise_estimate_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Register copies and frame state of the predictor.
  logic [CFG_DATA_W-1:0] cfg_width  = RST_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_height = RST_FRAME_HEIGHT;
  logic [CFG_STEP_W-1:0] cfg_step   = RST_SAMPLE_STEP;
  int unsigned           col_pos = 0;
  int unsigned           row_pos = 0;
  int unsigned           sample_total = 0;
  logic [LEVEL_W-1:0]    min_level = '1;
  logic [LEVEL_W-1:0]    last_sample = '0;
  longint unsigned       sq_sum = 0;
  bit                    pair_open = 1'b0;

  frame_stats_t stats_due[$];
  int unsigned  frames_predicted = 0;
  int unsigned  frames_checked = 0;
  int unsigned  pixels_sent = 0;
  int unsigned  reg_writes = 0;
  int unsigned  errors = 0;
  bit           steady = 1'b0;
  bit           hold_request = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Run timed out with %0d frame results outstanding.", stats_due.size());
    $display("== FAIL ==");
    $finish;
  end

  function automatic int unsigned eff_dim(logic [CFG_DATA_W-1:0] v);
    if (v < 3) return 3;
    if (v > DEF_MAX_DIM) return DEF_MAX_DIM;
    return 32'(v);
  endfunction

  function automatic bit grid_hit(int unsigned pos, int unsigned limit, int unsigned step);
    return pos >= 1 && pos + 1 < limit && ((pos - 1) % step) == 0;
  endfunction

  function automatic logic [15:0] pick_pixel(int pattern, logic [15:0] base);
    case (pattern)
      0:       return 16'($urandom);
      1:       return base + 16'($urandom_range(0, 15));
      default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    endcase
  endfunction

  task automatic clear_frame();
    min_level    = '1;
    sq_sum       = 0;
    sample_total = 0;
    last_sample  = '0;
    pair_open    = 1'b0;
  endtask

  // Advances the predicted frame by one accepted pixel.
  task automatic track_pixel(input logic [15:0] pix, input logic sof);
    int unsigned     w, h, st, diff;
    longint unsigned den, q, rem, scaled, root, cand;
    int              b;
    frame_stats_t    r;
    w  = eff_dim(cfg_width);
    h  = eff_dim(cfg_height);
    st = (cfg_step == 0) ? 1 : cfg_step;
    if (sof) begin
      col_pos = 0;
      row_pos = 0;
      clear_frame();
    end
    if (pair_open) begin
      diff = (pix >= last_sample) ? pix - last_sample : last_sample - pix;
      sq_sum += 64'(diff) * 64'(diff);
      pair_open = 1'b0;
    end
    if (grid_hit(row_pos, h, st) && grid_hit(col_pos, w, st)) begin
      if (pix < min_level) min_level = pix;
      sample_total++;
      last_sample = pix;
      pair_open = 1'b1;
    end
    if (col_pos + 1 >= w) begin
      pair_open = 1'b0;
      col_pos = 0;
      if (row_pos + 1 >= h) begin
        r = '0;
        if (sample_total == 0) begin
          r.empty = 1'b1;
        end else begin
          den    = 64'(sample_total) * 2;
          q      = sq_sum / den;
          rem    = sq_sum % den;
          scaled = (q << 16) + ((rem << 16) / den);
          root   = 0;
          for (b = 31; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (cand * cand <= scaled) root = cand;
          end
          r.background = min_level;
          r.noise      = root[NOISE_W-1:0];
          r.count      = sample_total[COUNT_W-1:0];
        end
        stats_due.push_back(r);
        frames_predicted++;
        row_pos = 0;
        clear_frame();
      end else begin
        row_pos++;
      end
    end else begin
      col_pos++;
    end
  endtask

  task automatic send_pixel(input logic [15:0] pix, input logic sof);
    if (!steady) begin
      while ($urandom_range(0, 99) < 36) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    in_tuser  <= sof;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    track_pixel(pix, sof);
    pixels_sent++;
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH:  cfg_width  = val;
      REG_FRAME_HEIGHT: cfg_height = val;
      REG_SAMPLE_STEP:  cfg_step   = val[CFG_STEP_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // Lets every expected result drain, then leaves room for the background arithmetic.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (stats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_until_frame_end();
    int unsigned target;
    target = frames_predicted + 1;
    while (frames_predicted < target) send_pixel(16'($urandom), 1'b0);
  endtask

  // A 3 by 3 frame has its single grid point at raster index 4.
  task automatic send_tiny_frame(input logic [15:0] sample, input logic [15:0] neighbour,
                                 input logic sof);
    int k;
    for (k = 0; k < 9; k++)
      send_pixel(k == 4 ? sample : (k == 5 ? neighbour : 16'($urandom)), sof && k == 0);
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_check
    frame_stats_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (stats_due.size() == 0) begin
        $display("%0t: unexpected result, tdata %h tuser %b", $time, out_tdata, out_tuser);
        errors++;
      end else begin
        want = stats_due.pop_front();
        check_field("background_level", want.background, out_tdata[LEVEL_W-1:0]);
        check_field("noise_level", want.noise, out_tdata[LEVEL_W +: NOISE_W]);
        check_field("sample_count", want.count, out_tdata[LEVEL_W+NOISE_W +: COUNT_W]);
        check_field("no_samples", want.empty, out_tuser);
        frames_checked++;
      end
    end
  end

  // Result side readiness; a hold request keeps it low for a long stretch.
  initial begin : result_ready
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_tready <= steady || ($urandom_range(0, 99) >= 36);
      end
    end
  end

  // Runs at the sizes left by reset, then shrinks the frame part way through.
  task automatic test_reset_geometry();
    int k;
    for (k = 0; k < 40; k++) send_pixel(16'($urandom), k == 0);
    settle();
    write_reg(REG_FRAME_WIDTH, 13'd47);
    write_reg(REG_FRAME_HEIGHT, 13'd3);
    send_until_frame_end();
    settle();
  endtask

  task automatic test_directed_cases();
    int k;
    write_reg(REG_FRAME_WIDTH, 13'd3);
    write_reg(REG_FRAME_HEIGHT, 13'd3);
    write_reg(REG_SAMPLE_STEP, 13'd1);
    send_tiny_frame(16'hFFFF, 16'h0000, 1'b1);
    // The next frame carries no start marker and follows on from the last one.
    send_tiny_frame(16'h0000, 16'hFFFF, 1'b0);
    for (k = 0; k < 4; k++) send_pixel(16'($urandom), k == 0);
    // A new start marker drops the partial frame above.
    send_tiny_frame(16'h8000, 16'h8000, 1'b1);
    settle();
  endtask

  task automatic test_large_geometry();
    int k;
    write_reg(REG_FRAME_WIDTH, '1);
    write_reg(REG_FRAME_HEIGHT, '1);
    write_reg(REG_SAMPLE_STEP, 13'd255);
    for (k = 0; k < 260; k++) send_pixel(16'($urandom), k == 0);
    settle();
    // The column position is already past the new width, so the row ends at once.
    write_reg(REG_FRAME_WIDTH, 13'd8);
    write_reg(REG_FRAME_HEIGHT, 13'd3);
    send_until_frame_end();
    settle();
    write_reg(REG_FRAME_WIDTH, 13'd3);
    write_reg(REG_FRAME_HEIGHT, 13'd4096);
    write_reg(REG_SAMPLE_STEP, 13'd0);
    for (k = 0; k < 17; k++) send_pixel(16'($urandom), k == 0);
    settle();
    write_reg(REG_FRAME_HEIGHT, 13'd4);
    send_until_frame_end();
    settle();
  endtask

  task automatic test_result_backpressure();
    int k;
    write_reg(REG_FRAME_WIDTH, 13'd3);
    write_reg(REG_FRAME_HEIGHT, 13'd3);
    write_reg(REG_SAMPLE_STEP, 13'd1);
    hold_request = 1'b1;
    for (k = 0; k < 90; k++) send_pixel(pick_pixel(0, 16'h0000), (k % 9) == 0);
    settle();
    steady = 1'b1;
    write_reg(REG_FRAME_WIDTH, 13'd6);
    write_reg(REG_FRAME_HEIGHT, 13'd4);
    write_reg(REG_SAMPLE_STEP, 13'd2);
    for (k = 0; k < 240; k++) send_pixel(pick_pixel(1, 16'h1000), (k % 24) == 0);
    settle();
    steady = 1'b0;
  endtask

  task automatic test_random_traffic();
    int unsigned pix_start, res_start, w, h, st, n;
    int          k, kind, pattern;
    logic [15:0] base;
    pix_start = pixels_sent;
    res_start = frames_predicted;
    while (pixels_sent - pix_start < RANDOM_PIXELS ||
           frames_predicted - res_start < RANDOM_RESULTS) begin
      settle();
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
      if ($urandom_range(0, 9) == 0) w = $urandom_range(13, 40);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
      case ($urandom_range(0, 5))
        0:       st = 0;
        1:       st = 255;
        2:       st = $urandom_range(0, 255);
        default: st = $urandom_range(1, 3);
      endcase
      write_reg(REG_FRAME_WIDTH, 13'(w));
      write_reg(REG_FRAME_HEIGHT, 13'(h));
      write_reg(REG_SAMPLE_STEP, {5'($urandom), 8'(st)});
      repeat ($urandom_range(1, 4)) begin
        // Mostly whole frames; some are cut short or arrive without a start marker.
        kind    = $urandom_range(0, 9);
        pattern = $urandom_range(0, 2);
        base    = 16'($urandom);
        n = eff_dim(cfg_width) * eff_dim(cfg_height);
        if (kind == 0) n = $urandom_range(1, n - 1);
        for (k = 0; k < n; k++) send_pixel(pick_pixel(pattern, base), k == 0 && kind != 1);
      end
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_addr  <= '0;
    cfg_data  <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_geometry();
    test_directed_cases();
    test_large_geometry();
    test_result_backpressure();
    test_random_traffic();
    settle();
    $display("Checked %0d frame results from %0d pixels across %0d register writes,",
             frames_checked, pixels_sent, reg_writes);
    $display("with restarts, unmarked frames, mid-frame resizing and result stalls.");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/fbne_pkg.sv
src/fbne_grid.sv
src/fbne_dp.sv
src/fbne_ctrl.sv
src/frame_background_noise_estimate_unit.sv
tb/frame_background_noise_estimate_unit_test.sv
